// File: src/scg_pkg.sv
`default_nettype none
package scg_pkg;

    // Default widths of the phase accumulator and the pulse counters
    localparam int PHASE_BITS_DEF = 32;
    localparam int PULSE_BITS_DEF = 16;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_INC_W  = 24;
    localparam int CFG_LEN_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC   = 2'd0,
        CFG_PULSE_TICKS = 2'd1,
        CFG_BEAT_TICKS  = 2'd2
    } cfg_index_t;

    localparam logic [CFG_INC_W-1:0] PHASE_INC_RST   = 24'd248303;
    localparam logic [CFG_LEN_W-1:0] PULSE_TICKS_RST = 16'd48;
    localparam logic [CFG_LEN_W-1:0] BEAT_TICKS_RST  = 16'd2400;

    // Swing: on-beat ratio R = (SWING_BASE + 3*swing) / SWING_DEN
    localparam int SWING_W = 11;
    localparam logic [SWING_W-1:0] SWING_MAX = 11'd1024;
    localparam int RATIO_W  = 14;
    localparam int THRESH_W = 16;
    localparam logic [RATIO_W-1:0]  SWING_BASE = 14'd5120;
    localparam logic [THRESH_W-1:0] SWING_DEN  = 16'd10240;

    // Pulse channels, clk at bit 0 up to beat at bit 8
    localparam int NUM_PULSES = 9;
    localparam int PULSE_BEAT = 8;

    typedef struct packed {
        logic beat;
        logic rst;
        logic div8;
        logic div4;
        logic div2;
        logic x8;
        logic x4;
        logic x2;
        logic clk;
    } pulse_vec_t;

endpackage
`default_nettype wire

// File: src/scg_eighth.sv
`default_nettype none
module scg_eighth #(
    parameter int PHASE_BITS = scg_pkg::PHASE_BITS_DEF
) (
    input  wire logic [PHASE_BITS-1:0]       phase,
    input  wire logic [scg_pkg::SWING_W-1:0] swing,
    output logic      [2:0]                  tick
);
    import scg_pkg::*;

    localparam int PROD_W = PHASE_BITS + THRESH_W;

    logic [SWING_W-1:0]  swing_sat;
    logic [RATIO_W-1:0]  ratio;
    logic [THRESH_W-1:0] ratio_w;
    logic [THRESH_W-1:0] off_w;
    logic [PROD_W-1:0]   phase_ext;
    logic [PROD_W-1:0]   scaled;
    logic [THRESH_W-1:0] q;
    logic [THRESH_W-1:0] thresh [7];
    logic [2:0]          count;

    // Saturate swing and form the on-beat ratio numerator
    always_comb
    begin
        swing_sat = (swing > SWING_MAX) ? SWING_MAX : swing;
        ratio     = SWING_BASE + RATIO_W'({swing_sat, 1'b0}) + RATIO_W'(swing_sat);
        ratio_w   = THRESH_W'(ratio);
        off_w     = SWING_DEN - ratio_w;
    end

    // 40960 * phase, as two shifted copies; its top bits are compared
    // against integer thresholds (all thresholds are multiples of 2^PHASE_BITS)
    always_comb
    begin
        phase_ext = PROD_W'(phase);
        scaled    = (phase_ext << 15) + (phase_ext << 13);
        q         = scaled[PROD_W-1 -: THRESH_W];
    end

    // Seven ascending thresholds: k*R in the on-beat half, then 4*R + k*(1-R)
    always_comb
    begin
        thresh[0] = ratio_w;
        thresh[1] = ratio_w << 1;
        thresh[2] = (ratio_w << 1) + ratio_w;
        thresh[3] = ratio_w << 2;
        thresh[4] = (ratio_w << 2) + off_w;
        thresh[5] = (ratio_w << 2) + (off_w << 1);
        thresh[6] = (ratio_w << 2) + (off_w << 1) + off_w;
    end

    // Tick is the number of thresholds reached
    always_comb
    begin
        count = 3'd0;
        for (int k = 0; k < 7; k++)
        begin
            count = count + 3'(q >= thresh[k]);
        end
        tick = count;
    end

endmodule
`default_nettype wire

// File: src/scg_pulses.sv
`default_nettype none
module scg_pulses #(
    parameter int PULSE_BITS = scg_pkg::PULSE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic                   running,
    input  wire scg_pkg::pulse_vec_t    fire,
    input  wire logic [PULSE_BITS-1:0]  pulse_len,
    input  wire logic [PULSE_BITS-1:0]  beat_len,
    output scg_pkg::pulse_vec_t         active
);
    import scg_pkg::*;

    logic [PULSE_BITS-1:0] cnt_reg  [NUM_PULSES];
    logic [PULSE_BITS-1:0] cnt_next [NUM_PULSES];
    logic [NUM_PULSES-1:0] fire_v;
    logic [NUM_PULSES-1:0] act_v;

    assign fire_v = fire;
    assign active = act_v;

    // Trigger raises a counter to its length (beat length on the beat channel); running beats count down
    always_comb
    begin
        logic [PULSE_BITS-1:0] len;
        logic [PULSE_BITS-1:0] val;
        for (int i = 0; i < NUM_PULSES; i++)
        begin
            len = (i == PULSE_BEAT) ? beat_len : pulse_len;
            val = (fire_v[i] && (len > cnt_reg[i])) ? len : cnt_reg[i];
            act_v[i] = (val != '0);
            cnt_next[i] = (running && act_v[i]) ? val - PULSE_BITS'(1) : val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PULSES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            for (int i = 0; i < NUM_PULSES; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

`ifndef ASSERT_OFF
    // Counters only move when a beat is processed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(cnt_reg[0]) && $stable(cnt_reg[PULSE_BEAT]))
        else $error("pulse counter changed without a step");

    // Stopped beats never count down: a counter can only rise or hold
    a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        step && !running |=> cnt_reg[0] >= $past(cnt_reg[0]))
        else $error("pulse counter decremented while stopped");

    // The beat pulse is not active while its counter is idle and nothing fires
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire_v == '0) && (cnt_reg[PULSE_BEAT] == '0) |-> !act_v[PULSE_BEAT])
        else $error("beat pulse active from an idle counter");
`endif

endmodule
`default_nettype wire

// File: src/swing_clock_generator_core.sv
`default_nettype none
// An accepted beat is processed at the next edge, given a free result slot, and
// its result is then held in the result register until it is taken.
// Throughput: one beat per cycle while the result slot is free; the input and
// result registers form a two-slot pipeline, and the whole per-beat update
// (phase add, tick compare, pulse counters) is the single step between them.
// Reset (rst_n low, asynchronous): stopped, phase, tick, beat count and all
// pulse counters cleared, configuration registers back to their defaults.
module swing_clock_generator_core #(
    parameter int PHASE_BITS = scg_pkg::PHASE_BITS_DEF,
    parameter int PULSE_BITS = scg_pkg::PULSE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_write,
    input  wire logic [scg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [scg_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            run_gate,
    input  wire logic                            run_button,
    input  wire logic                            reset_gate,
    input  wire logic                            reset_button,
    input  wire logic [scg_pkg::SWING_W-1:0]     swing_amount,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 clk_out,
    output logic                                 x2_out,
    output logic                                 x4_out,
    output logic                                 x8_out,
    output logic                                 div2_out,
    output logic                                 div4_out,
    output logic                                 div8_out,
    output logic                                 reset_out,
    output logic                                 run_out,
    output logic                                 beat_out
);
    import scg_pkg::*;

    localparam int SUM_W = ((PHASE_BITS > CFG_INC_W) ? PHASE_BITS : CFG_INC_W) + 1;

    // Configuration registers
    logic [CFG_INC_W-1:0] phase_inc_reg;
    logic [CFG_LEN_W-1:0] pulse_ticks_reg;
    logic [CFG_LEN_W-1:0] beat_ticks_reg;

    // Input stage
    logic               s1_valid_reg;
    logic [3:0]         levels_reg;
    logic [SWING_W-1:0] swing_reg;

    // Beat state
    logic                  running_reg;
    logic [3:0]            last_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [2:0]            tick_reg;
    logic [2:0]            bcount_reg;

    // Result stage
    logic       out_valid_reg;
    pulse_vec_t res_reg;
    logic       run_res_reg;

    // Step signals
    logic                  adv;
    logic [3:0]            rise;
    logic                  run_next;
    logic                  start;
    logic                  rst_edge;
    logic                  clr;
    logic [PHASE_BITS-1:0] phase0;
    logic [2:0]            tick0;
    logic [2:0]            bcount0;
    logic [SUM_W-1:0]      sum;
    logic                  wrapped;
    logic [PHASE_BITS-1:0] phase_next;
    logic [2:0]            bcount_next;
    logic [2:0]            tick_next;
    logic                  changed;
    pulse_vec_t            fire;
    pulse_vec_t            active;
    logic [PULSE_BITS-1:0] pulse_len;
    logic [PULSE_BITS-1:0] beat_len;

    // Handshake: step when the input stage holds a beat and the result slot frees
    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg   <= PHASE_INC_RST;
            pulse_ticks_reg <= PULSE_TICKS_RST;
            beat_ticks_reg  <= BEAT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PHASE_INC:   phase_inc_reg   <= cfg_data[CFG_INC_W-1:0];
                CFG_PULSE_TICKS: pulse_ticks_reg <= cfg_data[CFG_LEN_W-1:0];
                CFG_BEAT_TICKS:  beat_ticks_reg  <= cfg_data[CFG_LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            levels_reg <= {reset_button, reset_gate, run_button, run_gate};
            swing_reg  <= swing_amount;
        end
    end

    // Edge detect, run toggle, position clear
    always_comb
    begin
        rise     = levels_reg & ~last_reg;
        run_next = running_reg ^ rise[0] ^ rise[1];
        start    = !running_reg && run_next;
        rst_edge = rise[2] || rise[3];
        clr      = rst_edge || start;
        phase0   = clr ? '0 : phase_reg;
        tick0    = clr ? 3'd0 : tick_reg;
        bcount0  = clr ? 3'd0 : bcount_reg;
    end

    // Phase advance; any carry out is one wrap
    always_comb
    begin
        sum         = SUM_W'(phase0) + SUM_W'(phase_inc_reg);
        wrapped     = (sum[SUM_W-1:PHASE_BITS] != '0);
        phase_next  = sum[PHASE_BITS-1:0];
        bcount_next = bcount0 + 3'(wrapped);
    end

    scg_eighth #(
        .PHASE_BITS (PHASE_BITS)
    ) u_eighth (
        .phase (phase_next),
        .swing (swing_reg),
        .tick  (tick_next)
    );

    // Trigger decode
    always_comb
    begin
        changed   = run_next && ((tick_next != tick0) || wrapped);
        fire.rst  = rst_edge;
        fire.x8   = start || changed;
        fire.x4   = start || (changed && !tick_next[0]);
        fire.x2   = start || (changed && (tick_next[1:0] == 2'd0));
        fire.clk  = start || (changed && (tick_next == 3'd0));
        fire.beat = fire.clk;
        fire.div2 = start || (run_next && wrapped && !bcount_next[0]);
        fire.div4 = start || (run_next && wrapped && (bcount_next[1:0] == 2'd0));
        fire.div8 = start || (run_next && wrapped && (bcount_next == 3'd0));
        pulse_len = PULSE_BITS'(pulse_ticks_reg);
        beat_len  = PULSE_BITS'(beat_ticks_reg);
    end

    scg_pulses #(
        .PULSE_BITS (PULSE_BITS)
    ) u_pulses (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .running   (run_next),
        .fire      (fire),
        .pulse_len (pulse_len),
        .beat_len  (beat_len),
        .active    (active)
    );

    // Beat state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            last_reg    <= '0;
            phase_reg   <= '0;
            tick_reg    <= 3'd0;
            bcount_reg  <= 3'd0;
        end
        else if (adv)
        begin
            running_reg <= run_next;
            last_reg    <= levels_reg;
            phase_reg   <= run_next ? phase_next : phase0;
            tick_reg    <= run_next ? tick_next : tick0;
            bcount_reg  <= run_next ? bcount_next : bcount0;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg     <= run_next ? active : '0;
            run_res_reg <= run_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign clk_out   = res_reg.clk;
    assign x2_out    = res_reg.x2;
    assign x4_out    = res_reg.x4;
    assign x8_out    = res_reg.x8;
    assign div2_out  = res_reg.div2;
    assign div4_out  = res_reg.div4;
    assign div8_out  = res_reg.div8;
    assign reset_out = res_reg.rst;
    assign run_out   = run_res_reg;
    assign beat_out  = res_reg.beat;

`ifndef ASSERT_OFF
    // A stopped result carries no pulses
    a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !run_res_reg |-> (res_reg == '0))
        else $error("pulse output while stopped");

    // Every step leaves a result behind
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("step without result");

    // Beat position only moves on a step
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(bcount_reg) && $stable(tick_reg) && $stable(running_reg))
        else $error("beat state changed without a step");

    // A held input beat stays until it is processed
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg)
        else $error("input beat dropped");
`endif

endmodule
`default_nettype wire

// File: verif/swing_clock_generator_checker.sv
`timescale 1ns / 100ps

module swing_clock_generator_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration port
    input  wire logic                           cfg_write,
    input  wire logic [scg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scg_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic                           run_gate,
    input  wire logic                           run_button,
    input  wire logic                           reset_gate,
    input  wire logic                           reset_button,
    input  wire logic [scg_pkg::SWING_W-1:0]    swing_amount,
    // output channel
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic                           clk_out,
    input  wire logic                           x2_out,
    input  wire logic                           x4_out,
    input  wire logic                           x8_out,
    input  wire logic                           div2_out,
    input  wire logic                           div4_out,
    input  wire logic                           div8_out,
    input  wire logic                           reset_out,
    input  wire logic                           run_out,
    input  wire logic                           beat_out,
    // status toward the testbench top
    output int                                  fail_count,
    output int                                  pending,
    output int                                  checked_count
);
    import scg_pkg::*;

    // pulse channels, same order as pulse_vec_t
    localparam int CH_CLK  = 0;
    localparam int CH_X2   = 1;
    localparam int CH_X4   = 2;
    localparam int CH_X8   = 3;
    localparam int CH_DIV2 = 4;
    localparam int CH_DIV4 = 5;
    localparam int CH_DIV8 = 6;
    localparam int CH_RST  = 7;
    localparam int CH_BEAT = PULSE_BEAT;

    // bit positions in the level history
    localparam int LV_RUN_GATE     = 0;
    localparam int LV_RUN_BUTTON   = 1;
    localparam int LV_RESET_GATE   = 2;
    localparam int LV_RESET_BUTTON = 3;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic               run_gate;
        logic               run_button;
        logic               reset_gate;
        logic               reset_button;
        logic [SWING_W-1:0] swing;
    } tick_in_t;

    typedef struct packed {
        logic       run;
        pulse_vec_t pulses;
    } tick_result_t;

    string field_name [10] = '{"clk_out", "x2_out", "x4_out", "x8_out", "div2_out",
                               "div4_out", "div8_out", "reset_out", "beat_out", "run_out"};

    // shadow configuration
    logic [CFG_INC_W-1:0]      inc_reg;
    logic [CFG_LEN_W-1:0]      pulse_len;
    logic [CFG_LEN_W-1:0]      beat_len;

    // shadow clock state
    logic                      run_state;
    logic [3:0]                prev_levels;
    logic [PHASE_BITS_DEF-1:0] phase_acc;
    logic [2:0]                tick_idx;
    logic [2:0]                beat_count;
    logic [PULSE_BITS_DEF-1:0] pulse_cnt [NUM_PULSES];

    tick_result_t              expected_ticks [$];

    // eighth-tick position of the phase for a given swing, exact integer compare
    function automatic logic [2:0] tick_of_phase(input logic [PHASE_BITS_DEF-1:0] p,
                                                 input logic [SWING_W-1:0] sw);
        logic [63:0] ratio;
        logic [63:0] scaled;
        logic [63:0] split;
        logic [63:0] span;
        logic [63:0] t;
        ratio  = SWING_BASE + 64'd3 * sw;
        scaled = p * SWING_DEN;
        split  = ratio << PHASE_BITS_DEF;
        if (scaled < split)
        begin
            t = (64'd4 * scaled) / split;
        end
        else
        begin
            span = (SWING_DEN - ratio) << PHASE_BITS_DEF;
            t    = 64'd4 + (64'd4 * (scaled - split)) / span;
        end
        if (t > 64'd7)
            t = 64'd7;
        return t[2:0];
    endfunction

    // retrigger: counter takes the longer of what is left and the new length
    task automatic arm(input int ch, input logic [PULSE_BITS_DEF-1:0] len);
        if (len > pulse_cnt[ch])
            pulse_cnt[ch] = len;
    endtask

    task automatic clear_position();
        phase_acc  = '0;
        tick_idx   = '0;
        beat_count = '0;
    endtask

    // one sample tick through the shadow clock
    task automatic predict_tick(input tick_in_t t, output tick_result_t r);
        logic [3:0]                levels;
        logic [3:0]                rise;
        logic [SWING_W-1:0]        sw;
        logic                      was_running;
        logic [PHASE_BITS_DEF:0]   sum;
        logic                      wrapped;
        logic [2:0]                prev_tick;
        logic [2:0]                new_tick;
        int                        ch;
        levels      = {t.reset_button, t.reset_gate, t.run_button, t.run_gate};
        rise        = levels & ~prev_levels;
        prev_levels = levels;
        sw          = (t.swing > SWING_MAX) ? SWING_MAX : t.swing;
        was_running = run_state;
        r           = '0;

        if (rise[LV_RUN_GATE])
            run_state = ~run_state;
        if (rise[LV_RUN_BUTTON])
            run_state = ~run_state;

        if (rise[LV_RESET_GATE] || rise[LV_RESET_BUTTON])
        begin
            clear_position();
            arm(CH_RST, pulse_len);
        end

        // start: fresh position, every pulse but reset fires
        if (!was_running && run_state)
        begin
            clear_position();
            for (ch = CH_CLK; ch <= CH_DIV8; ch++)
                arm(ch, pulse_len);
            arm(CH_BEAT, beat_len);
        end

        // stopped: outputs low, counters frozen
        if (!run_state)
            return;

        sum       = {1'b0, phase_acc} + inc_reg;
        wrapped   = sum[PHASE_BITS_DEF];
        phase_acc = sum[PHASE_BITS_DEF-1:0];
        prev_tick = tick_idx;
        if (wrapped)
            beat_count = beat_count + 3'd1;
        new_tick = tick_of_phase(phase_acc, sw);
        tick_idx = new_tick;

        if (new_tick != prev_tick || wrapped)
        begin
            arm(CH_X8, pulse_len);
            if (!new_tick[0])
                arm(CH_X4, pulse_len);
            if (new_tick[1:0] == 2'd0)
                arm(CH_X2, pulse_len);
            if (new_tick == 3'd0)
            begin
                arm(CH_CLK, pulse_len);
                arm(CH_BEAT, beat_len);
            end
        end
        if (wrapped)
        begin
            if (!beat_count[0])
                arm(CH_DIV2, pulse_len);
            if (beat_count[1:0] == 2'd0)
                arm(CH_DIV4, pulse_len);
            if (beat_count == 3'd0)
                arm(CH_DIV8, pulse_len);
        end

        // sample, then count down
        for (ch = 0; ch < NUM_PULSES; ch++)
        begin
            r.pulses[ch] = (pulse_cnt[ch] != '0);
            if (pulse_cnt[ch] != '0)
                pulse_cnt[ch] = pulse_cnt[ch] - 1'b1;
        end
        r.run = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] MISMATCH %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tick_in_t     beat_in;
        tick_result_t got;
        tick_result_t want;
        int           i;
        if (!rst_n)
        begin
            inc_reg       = PHASE_INC_RST;
            pulse_len     = PULSE_TICKS_RST;
            beat_len      = BEAT_TICKS_RST;
            run_state     = 1'b0;
            prev_levels   = '0;
            clear_position();
            for (i = 0; i < NUM_PULSES; i++)
                pulse_cnt[i] = '0;
            expected_ticks.delete();
            fail_count    = 0;
            checked_count = 0;
            pending      <= 0;
        end
        else
        begin
            // register write
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PHASE_INC:   inc_reg   = cfg_data[CFG_INC_W-1:0];
                    CFG_PULSE_TICKS: pulse_len = cfg_data[CFG_LEN_W-1:0];
                    CFG_BEAT_TICKS:  beat_len  = cfg_data[CFG_LEN_W-1:0];
                    default:         ;
                endcase
            end

            // result beat against the oldest expectation
            if (out_valid && out_ready)
            begin
                got = {run_out, beat_out, reset_out, div8_out, div4_out, div2_out,
                       x8_out, x4_out, x2_out, clk_out};
                if (expected_ticks.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    for (i = 0; i < 10; i++)
                    begin
                        if (got[i] !== want[i])
                            report_mismatch($sformatf("result %0d: %s got %b want %b",
                                checked_count, field_name[i], got[i], want[i]));
                    end
                    checked_count++;
                end
            end

            // input beat: predict its result
            if (in_valid && in_ready)
            begin
                beat_in = {run_gate, run_button, reset_gate, reset_button, swing_amount};
                predict_tick(beat_in, want);
                expected_ticks.push_back(want);
            end

            pending <= expected_ticks.size();
        end
    end

endmodule

// File: verif/swing_clock_generator_core_tb.sv
`timescale 1ns / 100ps

module swing_clock_generator_core_tb;
    import scg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int LATENCY_PAD    = 8;
    localparam logic [SWING_W-1:0]   SWING_TOP = '1;
    localparam logic [CFG_INC_W-1:0] INC_MAX = '1;
    localparam logic [CFG_LEN_W-1:0] LEN_MAX = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  run_gate;
    logic                  run_button;
    logic                  reset_gate;
    logic                  reset_button;
    logic [SWING_W-1:0]    swing_amount;
    logic                  out_valid;
    logic                  out_ready;
    logic                  clk_out;
    logic                  x2_out;
    logic                  x4_out;
    logic                  x8_out;
    logic                  div2_out;
    logic                  div4_out;
    logic                  div8_out;
    logic                  reset_out;
    logic                  run_out;
    logic                  beat_out;

    int                    fail_count;
    int                    pending;
    int                    checked_count;

    // stimulus bookkeeping
    int                    tx_gap_max    = 12;
    int                    rx_gap_max    = 12;
    int                    hold_requests = 0;
    int                    ticks_sent    = 0;
    int                    settings_used = 1;
    logic [3:0]            cur_levels    = '0;   // {reset_button, reset_gate, run_button, run_gate}
    logic                  run_guess     = 1'b0;
    logic [SWING_W-1:0]    cur_swing     = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    swing_clock_generator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .run_gate     (run_gate),
        .run_button   (run_button),
        .reset_gate   (reset_gate),
        .reset_button (reset_button),
        .swing_amount (swing_amount),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .clk_out      (clk_out),
        .x2_out       (x2_out),
        .x4_out       (x4_out),
        .x8_out       (x8_out),
        .div2_out     (div2_out),
        .div4_out     (div4_out),
        .div8_out     (div8_out),
        .reset_out    (reset_out),
        .run_out      (run_out),
        .beat_out     (beat_out)
    );

    swing_clock_generator_checker tick_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .run_gate      (run_gate),
        .run_button    (run_button),
        .reset_gate    (reset_gate),
        .reset_button  (reset_button),
        .swing_amount  (swing_amount),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .clk_out       (clk_out),
        .x2_out        (x2_out),
        .x4_out        (x4_out),
        .x8_out        (x8_out),
        .div2_out      (div2_out),
        .div4_out      (div4_out),
        .div8_out      (div8_out),
        .reset_out     (reset_out),
        .run_out       (run_out),
        .beat_out      (beat_out),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // offer one tick beat after a random gap, return at the edge that takes it
    task automatic send_beat(input logic [3:0] lv, input logic [SWING_W-1:0] sw);
        int unsigned pause;
        logic [3:0]  rise;
        pause = $urandom_range(0, tx_gap_max);
        if (pause != 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid     <= 1'b1;
        run_gate     <= lv[0];
        run_button   <= lv[1];
        reset_gate   <= lv[2];
        reset_button <= lv[3];
        swing_amount <= sw;
        @(posedge clk iff in_ready);
        rise       = lv & ~cur_levels;
        run_guess  = run_guess ^ rise[0] ^ rise[1];
        cur_levels = lv;
        ticks_sent++;
    endtask

    // let every expected result come out, with no new beat offered
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic reprogram(input logic [CFG_INC_W-1:0] inc,
                             input logic [CFG_LEN_W-1:0] plen,
                             input logic [CFG_LEN_W-1:0] blen);
        drain_pipeline();
        cfg_write <= 1'b1;
        cfg_index <= CFG_PHASE_INC;
        cfg_data  <= CFG_DATA_W'(inc);
        @(posedge clk);
        cfg_index <= CFG_PULSE_TICKS;
        cfg_data  <= CFG_DATA_W'(plen);
        @(posedge clk);
        cfg_index <= CFG_BEAT_TICKS;
        cfg_data  <= CFG_DATA_W'(blen);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // random ticks: mostly held levels with sparse edges, plus some noise
    task automatic run_phase(input logic [CFG_INC_W-1:0] inc,
                             input logic [CFG_LEN_W-1:0] plen,
                             input logic [CFG_LEN_W-1:0] blen,
                             input int count, input bit quiet,
                             input int tx_gap, input int rx_gap, input bit squeeze);
        logic [3:0]  lv;
        int          n;
        int          b;
        int unsigned odds;
        reprogram(inc, plen, blen);
        tx_gap_max = tx_gap;
        rx_gap_max = rx_gap;
        if (squeeze)
            hold_requests++;
        for (n = 0; n < count; n++)
        begin
            if (!quiet && $urandom_range(0, 11) == 0)
            begin
                lv = 4'($urandom_range(0, 15));
            end
            else
            begin
                lv = cur_levels;
                for (b = 0; b < 4; b++)
                begin
                    if (lv[b])
                    begin
                        if ($urandom_range(0, 3) == 0)
                            lv[b] = 1'b0;
                    end
                    else
                    begin
                        // stopped: restart soon; running: stop or reset rarely
                        if (b < 2)
                            odds = !run_guess ? 6 : (quiet ? 5000 : 60);
                        else
                            odds = quiet ? 5000 : 50;
                        if ($urandom_range(1, odds) == 1)
                            lv[b] = 1'b1;
                    end
                end
            end
            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       cur_swing = SWING_W'($urandom_range(SWING_MAX + 1, SWING_TOP));
                    1:       cur_swing = SWING_MAX;
                    2:       cur_swing = '0;
                    default: cur_swing = SWING_W'($urandom_range(0, SWING_MAX));
                endcase
            end
            send_beat(lv, cur_swing);
        end
    endtask

    // receiver: random ready gaps, one long hold-off on request
    initial
    begin : receiver
        int unsigned pause;
        int          holds_served;
        holds_served = 0;
        out_ready    = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            pause = $urandom_range(0, rx_gap_max);
            if (hold_requests != holds_served)
            begin
                pause = HOLD_CYCLES;
                holds_served++;
            end
            if (pause != 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk iff out_valid);
        end
    end

    // watchdog on cycles without any accepted beat, taken result or register write
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                idle = 0;
            else
                idle++;
        end
        $display("no progress for %0d cycles, %0d results still due", idle, pending);
        $display("swing_clock_generator_core test failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_PHASE_INC;
        cfg_data     = '0;
        in_valid     = 1'b0;
        run_gate     = 1'b0;
        run_button   = 1'b0;
        reset_gate   = 1'b0;
        reset_button = 1'b0;
        swing_amount = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset configuration
        send_beat(4'b0000, 11'd0);               // stopped, all low
        send_beat(4'b0100, 11'd0);               // reset while stopped
        send_beat(4'b0000, 11'd0);
        send_beat(4'b0001, 11'd0);               // start from the run gate
        send_beat(4'b0001, SWING_MAX);
        send_beat(4'b0001, SWING_TOP);           // swing saturates
        send_beat(4'b0000, SWING_MAX + 1'b1);
        send_beat(4'b1000, 11'd512);             // reset button while running
        send_beat(4'b1100, 11'd512);             // reset gate on top
        send_beat(4'b0000, 11'd512);
        send_beat(4'b0010, 11'd300);             // stop from the button
        send_beat(4'b0000, 11'd300);
        send_beat(4'b0011, 11'd0);               // both run edges cancel
        send_beat(4'b0000, 11'd0);
        send_beat(4'b0010, 11'd1);               // start from the button
        send_beat(4'b0010, 11'd1023);
        send_beat(4'b1111, SWING_TOP);           // gate stops, resets rise together
        send_beat(4'b0000, 11'd0);

        // directed, phase frozen and zero pulse lengths
        reprogram('0, '0, '0);
        send_beat(4'b0001, 11'd0);
        send_beat(4'b0001, 11'd700);
        send_beat(4'b0101, 11'd700);
        send_beat(4'b0001, SWING_TOP);
        send_beat(4'b0000, 11'd0);
        send_beat(4'b0010, 11'd0);

        // random phases
        run_phase(INC_MAX, 16'd1, 16'd1, 1100, 1'b1, 12, 12, 1'b0);
        run_phase(CFG_INC_W'($urandom_range(24'h800000, INC_MAX)), 16'd3, 16'd17,
                  200, 1'b0, 0, 0, 1'b0);
        run_phase(CFG_INC_W'($urandom_range(1, INC_MAX)), CFG_LEN_W'($urandom_range(1, 30)),
                  CFG_LEN_W'($urandom_range(1, 300)), 200, 1'b0, 12, 12, 1'b1);
        run_phase(24'd1, LEN_MAX, LEN_MAX, 100, 1'b0, 12, 0, 1'b0);
        run_phase(INC_MAX, 16'd2, 16'd7, 200, 1'b0, 0, 12, 1'b0);

        drain_pipeline();
        $display("covered %0d ticks under %0d register settings, %0d results compared",
                 ticks_sent, settings_used, checked_count);
        $display("increments 0 to full scale, pulse lengths 0 to 65535, swing 0 to 2047");
        if (fail_count == 0)
            $display("swing_clock_generator_core test passed");
        else
            $display("swing_clock_generator_core test failed");
        $finish;
    end

endmodule
